/* hw/rtl/bmphdr_pkg.sv */
package bmphdr_pkg;

  localparam logic [7:0]  MagicFirst   = 8'h42;
  localparam logic [7:0]  MagicSecond  = 8'h4D;
  localparam logic [19:0] MaxDimReset  = 20'd1000000;
  localparam logic [31:0] CoreHdrLen   = 32'd12;
  localparam logic [31:0] MinV2HdrLen  = 32'd16;
  localparam logic [31:0] InfoHdrLen   = 32'd40;

  localparam int unsigned OutDataWidth = 112;

  typedef enum logic [1:0] {
    StatusLoaded  = 2'd0,
    StatusUnknown = 2'd1,
    StatusError   = 2'd2
  } status_e;

  typedef struct packed {
    logic [31:0] hdr_len;
    logic [31:0] width_raw;
    logic [31:0] height_raw;
    logic [31:0] xres_raw;
    logic [31:0] yres_raw;
  } fields_t;

  typedef struct packed {
    logic    settle;
    logic    finish;
    status_e status;
  } decision_t;

  typedef struct packed {
    status_e     status;
    logic [19:0] width;
    logic [19:0] height;
    logic        res_valid;
    logic [30:0] xres;
    logic [30:0] yres;
  } result_t;

endpackage

/* hw/rtl/bmphdr_parse.sv */
module bmphdr_parse (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  go_i,
  input  logic [7:0]            byte_i,
  input  logic                  last_i,
  output bmphdr_pkg::fields_t   fields_o,
  output bmphdr_pkg::decision_t dec_o
);
  import bmphdr_pkg::*;

  localparam logic [5:0] PosFirst    = 6'd0;
  localparam logic [5:0] PosSecond   = 6'd1;
  localparam logic [5:0] PosHdrLo    = 6'd14;
  localparam logic [5:0] PosHdrHi    = 6'd17;
  localparam logic [5:0] PosDimLo    = 6'd18;
  localparam logic [5:0] PosCoreWHi  = 6'd19;
  localparam logic [5:0] PosCoreHHi  = 6'd21;
  localparam logic [5:0] PosV2WHi    = 6'd21;
  localparam logic [5:0] PosDimHi    = 6'd25;
  localparam logic [5:0] PosResLo    = 6'd38;
  localparam logic [5:0] PosXResHi   = 6'd41;
  localparam logic [5:0] PosResHi    = 6'd45;
  localparam logic [5:0] PosSaturate = 6'd63;

  function automatic logic [31:0] put_byte(logic [31:0] word, logic [1:0] lane,
                                           logic [7:0] b);
    logic [31:0] shifted;
    shifted = {24'd0, b} << {lane, 3'b000};
    return word | shifted;
  endfunction

  logic [5:0] pos_q, pos_d;
  logic       given_q, given_d;
  fields_t    fields_q, fields_d;
  logic [1:0] lane_off2;
  logic [1:0] lane_off0;
  logic       settle;
  logic       finish;
  status_e    status;

  assign lane_off2 = pos_q[1:0] - 2'd2;
  assign lane_off0 = pos_q[1:0];

  always_comb begin
    fields_d = fields_q;
    settle   = 1'b0;
    finish   = 1'b0;
    status   = StatusError;
    if (!given_q) begin
      if (pos_q == PosFirst) begin
        if (byte_i != MagicFirst) begin
          settle = 1'b1;
          status = StatusUnknown;
        end
      end else if (pos_q == PosSecond) begin
        if (byte_i != MagicSecond) begin
          settle = 1'b1;
          status = StatusUnknown;
        end
      end else if (pos_q >= PosHdrLo && pos_q <= PosHdrHi) begin
        fields_d.hdr_len = put_byte(fields_q.hdr_len, lane_off2, byte_i);
        if (pos_q == PosHdrHi && fields_d.hdr_len != CoreHdrLen &&
            fields_d.hdr_len < MinV2HdrLen) begin
          settle = 1'b1;
          status = StatusError;
        end
      end else if (pos_q >= PosDimLo && pos_q <= PosDimHi) begin
        if (fields_q.hdr_len == CoreHdrLen) begin
          if (pos_q <= PosCoreWHi) begin
            fields_d.width_raw = put_byte(fields_q.width_raw, lane_off2, byte_i);
          end else if (pos_q <= PosCoreHHi) begin
            fields_d.height_raw = put_byte(fields_q.height_raw, lane_off0, byte_i);
          end
        end else begin
          if (pos_q <= PosV2WHi) begin
            fields_d.width_raw = put_byte(fields_q.width_raw, lane_off2, byte_i);
          end else begin
            fields_d.height_raw = put_byte(fields_q.height_raw, lane_off2, byte_i);
          end
        end
        if (pos_q == PosDimHi && fields_q.hdr_len < InfoHdrLen) begin
          finish = 1'b1;
        end
      end else if (pos_q >= PosResLo && pos_q <= PosResHi) begin
        if (pos_q <= PosXResHi) begin
          fields_d.xres_raw = put_byte(fields_q.xres_raw, lane_off2, byte_i);
        end else begin
          fields_d.yres_raw = put_byte(fields_q.yres_raw, lane_off2, byte_i);
        end
        if (pos_q == PosResHi) begin
          finish = 1'b1;
        end
      end
      if (!settle && !finish && last_i) begin
        settle = 1'b1;
        status = (pos_q == PosFirst) ? StatusUnknown : StatusError;
      end
    end
  end

  always_comb begin
    pos_d   = pos_q;
    given_d = given_q;
    if (last_i) begin
      pos_d   = '0;
      given_d = 1'b0;
    end else if (!given_q) begin
      if (settle || finish) begin
        given_d = 1'b1;
      end else if (pos_q < PosSaturate) begin
        pos_d = pos_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      given_q  <= 1'b0;
      fields_q <= '0;
    end else if (go_i) begin
      pos_q    <= pos_d;
      given_q  <= given_d;
      fields_q <= last_i ? '0 : fields_d;
    end
  end

  assign fields_o      = fields_d;
  assign dec_o.settle  = settle || finish;
  assign dec_o.finish  = finish;
  assign dec_o.status  = status;

endmodule

/* hw/rtl/bmphdr_check.sv */
module bmphdr_check (
  input  bmphdr_pkg::fields_t   fields_i,
  input  bmphdr_pkg::decision_t dec_i,
  input  logic [19:0]           max_dim_i,
  output bmphdr_pkg::result_t   result_o
);
  import bmphdr_pkg::*;

  function automatic logic [31:0] abs32(logic [31:0] raw);
    return raw[31] ? (32'd0 - raw) : raw;
  endfunction

  logic        core;
  logic [31:0] w;
  logic [31:0] h;
  logic [31:0] max_ext;
  logic        res_ok;
  logic        dims_ok;

  assign core    = (fields_i.hdr_len == CoreHdrLen);
  assign w       = core ? {16'd0, fields_i.width_raw[15:0]} : abs32(fields_i.width_raw);
  assign h       = core ? {16'd0, fields_i.height_raw[15:0]} : abs32(fields_i.height_raw);
  assign max_ext = {12'd0, max_dim_i};
  assign res_ok  = !core && (fields_i.hdr_len >= InfoHdrLen) &&
                   (fields_i.xres_raw != '0) && !fields_i.xres_raw[31] &&
                   (fields_i.yres_raw != '0) && !fields_i.yres_raw[31];
  assign dims_ok = (w != '0) && (h != '0) && (w <= max_ext) && (h <= max_ext);

  always_comb begin
    result_o = '0;
    if (dec_i.finish) begin
      if (dims_ok) begin
        result_o.status    = StatusLoaded;
        result_o.width     = w[19:0];
        result_o.height    = h[19:0];
        result_o.res_valid = res_ok;
        result_o.xres      = res_ok ? fields_i.xres_raw[30:0] : '0;
        result_o.yres      = res_ok ? fields_i.yres_raw[30:0] : '0;
      end else begin
        result_o.status = StatusError;
      end
    end else begin
      result_o.status = dec_i.status;
    end
  end

endmodule

/* hw/rtl/bmp_header_metadata_parser_core.sv */
// Path: a settling byte is held in the input register, then its result is registered in the result register.
// Throughput: one byte per cycle while the result side is ready; a stalled result
// holds the next byte in the input register and stops further transfers until it is taken.
// Reset: rst_ni is asynchronous and active low; it rearms the parser, drops both
// valid flags and restores max_dimension to 1000000.
module bmp_header_metadata_parser_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [19:0]                            cfg_wdata_i,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // Fields from bit 0: data_byte[7:0].
  input  logic [7:0]                             s_axis_tdata_i,
  input  logic                                   s_axis_tlast_i,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // Fields from bit 0: status[1:0], image_width[21:2], image_height[41:22],
  // resolution_valid[42], x_pels_per_metre[73:43], y_pels_per_metre[104:74], zeros.
  output logic [bmphdr_pkg::OutDataWidth-1:0]    m_axis_tdata_o
);
  import bmphdr_pkg::*;

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_last_q;
  logic        out_valid_q;
  result_t     out_q;
  logic [19:0] max_dim_q;
  logic        go;
  fields_t     fields;
  decision_t   dec;
  result_t     result;

  assign go              = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dim_q <= MaxDimReset;
    end else if (cfg_we_i) begin
      max_dim_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  bmphdr_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .go_i     (go),
    .byte_i   (in_byte_q),
    .last_i   (in_last_q),
    .fields_o (fields),
    .dec_o    (dec)
  );

  bmphdr_check u_check (
    .fields_i  (fields),
    .dec_i     (dec),
    .max_dim_i (max_dim_q),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (go && dec.settle) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && dec.settle) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_q.yres, out_q.xres, out_q.res_valid,
                            out_q.height, out_q.width, out_q.status};

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status == StatusLoaded |-> out_q.width != '0 && out_q.height != '0)
    else $error("loaded result with a zero dimension");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status != StatusLoaded |->
      out_q.width == '0 && out_q.height == '0 && !out_q.res_valid &&
      out_q.xres == '0 && out_q.yres == '0)
    else $error("error result carries a payload");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.res_valid |-> out_q.xres != '0 && out_q.yres != '0)
    else $error("valid resolution with a zero value");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready_i |-> !go || !dec.settle)
    else $error("result register overwritten while stalled");
`endif

endmodule

/* test/tb_bmp_header_metadata_parser_core.sv */
`timescale 1ns / 100ps

module tb_bmp_header_metadata_parser_core;
  import bmphdr_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned FileHdrBytes = 14;

  typedef struct {
    status_e     status;
    logic [19:0] width;
    logic [19:0] height;
    logic        res_valid;
    logic [30:0] xres;
    logic [30:0] yres;
  } header_info_t;

  typedef enum {MagicOk, MagicBadFirst, MagicBadSecond} magic_fault_e;

  class bmp_header_predictor;
    logic [19:0]  max_dim;
    logic [5:0]   pos;
    bit           given;
    logic [31:0]  hdr_len;
    logic [31:0]  width_raw;
    logic [31:0]  height_raw;
    logic [31:0]  xres_raw;
    logic [31:0]  yres_raw;
    header_info_t expected_headers[$];
    int unsigned  mismatches;

    function new();
      max_dim = MaxDimReset;
      mismatches = 0;
      rearm();
    endfunction

    function void rearm();
      pos = '0;
      given = 1'b0;
      hdr_len = '0;
      width_raw = '0;
      height_raw = '0;
      xres_raw = '0;
      yres_raw = '0;
    endfunction

    function header_info_t rejected(status_e st);
      header_info_t r;
      r.status = st;
      r.width = '0;
      r.height = '0;
      r.res_valid = 1'b0;
      r.xres = '0;
      r.yres = '0;
      return r;
    endfunction

    function header_info_t decode_header();
      header_info_t r;
      logic [31:0]  w;
      logic [31:0]  h;
      r = rejected(StatusLoaded);
      if (hdr_len == CoreHdrLen) begin
        w = {16'h0, width_raw[15:0]};
        h = {16'h0, height_raw[15:0]};
      end else begin
        w = width_raw[31] ? -width_raw : width_raw;
        h = height_raw[31] ? -height_raw : height_raw;
        if (hdr_len >= InfoHdrLen && xres_raw != 0 && !xres_raw[31] &&
            yres_raw != 0 && !yres_raw[31]) begin
          r.res_valid = 1'b1;
          r.xres = xres_raw[30:0];
          r.yres = yres_raw[30:0];
        end
      end
      if (w == 0 || h == 0 || w > {12'h0, max_dim} || h > {12'h0, max_dim}) begin
        return rejected(StatusError);
      end
      r.width = w[19:0];
      r.height = h[19:0];
      return r;
    endfunction

    function void accept_byte(logic [7:0] b, logic last);
      bit           done;
      int           p;
      header_info_t r;
      done = 1'b0;
      p = int'(pos);
      if (!given) begin
        if (p == 0) begin
          if (b != MagicFirst) begin
            r = rejected(StatusUnknown);
            done = 1'b1;
          end
        end else if (p == 1) begin
          if (b != MagicSecond) begin
            r = rejected(StatusUnknown);
            done = 1'b1;
          end
        end else if (p >= FileHdrBytes && p < FileHdrBytes + 4) begin
          hdr_len[8*(p-FileHdrBytes) +: 8] = b;
          if (p == FileHdrBytes + 3 && hdr_len != CoreHdrLen && hdr_len < MinV2HdrLen) begin
            r = rejected(StatusError);
            done = 1'b1;
          end
        end else if (p >= 18 && p <= 25) begin
          if (hdr_len == CoreHdrLen) begin
            if (p <= 19) begin
              width_raw[8*(p-18) +: 8] = b;
            end else if (p <= 21) begin
              height_raw[8*(p-20) +: 8] = b;
            end
          end else if (p <= 21) begin
            width_raw[8*(p-18) +: 8] = b;
          end else begin
            height_raw[8*(p-22) +: 8] = b;
          end
          if (p == 25 && hdr_len < InfoHdrLen) begin
            r = decode_header();
            done = 1'b1;
          end
        end else if (p >= 38 && p <= 45) begin
          if (p <= 41) begin
            xres_raw[8*(p-38) +: 8] = b;
          end else begin
            yres_raw[8*(p-42) +: 8] = b;
          end
          if (p == 45) begin
            r = decode_header();
            done = 1'b1;
          end
        end
        if (!done && last) begin
          r = rejected((p == 0) ? StatusUnknown : StatusError);
          done = 1'b1;
        end
        if (done) begin
          given = 1'b1;
          expected_headers.push_back(r);
        end else if (pos < 6'd63) begin
          pos = pos + 6'd1;
        end
      end
      if (last) begin
        rearm();
      end
    endfunction

    function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
        $error("%s: expected %0d, got %0d", name, exp, act);
        mismatches++;
      end
    endfunction

    function void check_header_result(logic [OutDataWidth-1:0] d);
      header_info_t e;
      if (expected_headers.size() == 0) begin
        $error("result transfer with no expected header outcome: %h", d);
        mismatches++;
        return;
      end
      e = expected_headers.pop_front();
      compare_field("status", e.status, d[1:0]);
      compare_field("image_width", e.width, d[21:2]);
      compare_field("image_height", e.height, d[41:22]);
      compare_field("resolution_valid", e.res_valid, d[42]);
      compare_field("x_pels_per_metre", e.xres, d[73:43]);
      compare_field("y_pels_per_metre", e.yres, d[104:74]);
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we;
  logic [19:0]             cfg_wdata;
  logic                    byte_valid;
  logic                    byte_ready;
  logic [7:0]              byte_data;
  logic                    byte_last;
  logic                    result_valid;
  logic                    result_ready;
  logic [OutDataWidth-1:0] result_data;

  bmp_header_predictor predictor;
  bit                  steady;
  int unsigned         cycles;

  bmp_header_metadata_parser_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (byte_valid),
    .s_axis_tready_o (byte_ready),
    .s_axis_tdata_i  (byte_data),
    .s_axis_tlast_i  (byte_last),
    .m_axis_tvalid_o (result_valid),
    .m_axis_tready_i (result_ready),
    .m_axis_tdata_o  (result_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] pick_dimension(logic [19:0] limit);
    logic [31:0] top;
    top = (limit == 0) ? 32'd1 : {12'h0, limit};
    case ($urandom_range(19))
      0: return 32'd0;
      1: return top;
      2: return top + 1 + $urandom_range(1000);
      3, 4: return -$urandom_range(1, top);
      5: return 32'h8000_0000;
      6: return $urandom;
      7, 8, 9: return $urandom_range(1, (top > 4000) ? 4000 : top);
      default: return $urandom_range(1, top);
    endcase
  endfunction

  function automatic logic [31:0] pick_resolution();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'h8000_0000 | $urandom;
      2: return $urandom;
      3: return 32'h7FFF_FFFF;
      4: return 32'd1;
      default: return $urandom_range(1, 20000);
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!steady && $urandom_range(99) < 36) begin
      byte_valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_valid <= 1'b1;
    byte_data <= b;
    byte_last <= last;
    @(posedge clk_i);
    while (!byte_ready) @(posedge clk_i);
    predictor.accept_byte(b, last);
  endtask

  task automatic send_file(input logic [31:0] hlen, input logic [31:0] w,
                           input logic [31:0] h, input logic [31:0] xr,
                           input logic [31:0] yr, input int len,
                           input magic_fault_e fault);
    logic [7:0] img [0:79];
    for (int i = 0; i < 80; i++) img[i] = 8'($urandom_range(255));
    img[0] = MagicFirst;
    img[1] = MagicSecond;
    if (fault == MagicBadFirst) img[0] = MagicFirst ^ 8'($urandom_range(1, 255));
    if (fault == MagicBadSecond) img[1] = MagicSecond ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < 4; i++) begin
      img[FileHdrBytes+i] = hlen[8*i +: 8];
      img[38+i] = xr[8*i +: 8];
      img[42+i] = yr[8*i +: 8];
      if (hlen == CoreHdrLen) begin
        if (i < 2) begin
          img[18+i] = w[8*i +: 8];
          img[20+i] = h[8*i +: 8];
        end
      end else begin
        img[18+i] = w[8*i +: 8];
        img[22+i] = h[8*i +: 8];
      end
    end
    for (int i = 0; i < len; i++) send_byte(img[i], i == len - 1);
  endtask

  task automatic send_random_file(output int len);
    logic [31:0]  hlen;
    int unsigned  pick;
    magic_fault_e fault;
    pick = $urandom_range(99);
    if (pick < 20) begin
      hlen = CoreHdrLen;
    end else if (pick < 45) begin
      hlen = $urandom_range(16, 39);
    end else if (pick < 60) begin
      hlen = InfoHdrLen;
    end else if (pick < 78) begin
      hlen = $urandom_range(41, 255);
    end else if (pick < 88) begin
      hlen = $urandom;
    end else begin
      hlen = $urandom_range(0, 14);
      if (hlen >= 12) hlen = hlen + 1;
    end
    pick = $urandom_range(99);
    fault = (pick < 4) ? MagicBadFirst : (pick < 8) ? MagicBadSecond : MagicOk;
    pick = $urandom_range(99);
    if (pick < 60) begin
      len = $urandom_range(46, 80);
    end else if (pick < 75) begin
      case ($urandom_range(5))
        0: len = 18;
        1: len = 17;
        2: len = 26;
        3: len = 25;
        4: len = 46;
        default: len = 45;
      endcase
    end else if (pick < 90) begin
      len = $urandom_range(3, 44);
    end else begin
      len = $urandom_range(1, 2);
    end
    send_file(hlen, pick_dimension(predictor.max_dim), pick_dimension(predictor.max_dim),
              pick_resolution(), pick_resolution(), len, fault);
  endtask

  task automatic run_phase(input int unsigned min_bytes, input int unsigned min_files);
    int unsigned nbytes;
    int unsigned nfiles;
    int          len;
    nbytes = 0;
    nfiles = 0;
    while (nbytes < min_bytes || nfiles < min_files) begin
      send_random_file(len);
      nbytes += len;
      nfiles++;
    end
    byte_valid <= 1'b0;
  endtask

  task automatic write_max_dimension(input logic [19:0] value);
    while (predictor.expected_headers.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    predictor.max_dim = value;
  endtask

  initial begin
    result_ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && result_valid && result_ready) predictor.check_header_result(result_data);
      result_ready <= steady || ($urandom_range(99) >= 36);
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    predictor = new();
    steady = 1'b0;
    rst_ni <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    byte_valid <= 1'b0;
    byte_data <= '0;
    byte_last <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Wrong magic, a lone first byte, and a file that ends right after the magic.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(MagicFirst, 1'b1);
    send_byte(MagicFirst, 1'b0);
    send_byte(MagicSecond, 1'b1);
    // A bad second byte settles at once; the bytes after it are ignored until the last one.
    send_byte(MagicFirst, 1'b0);
    send_byte(8'h4E, 1'b0);
    send_byte(8'h00, 1'b1);
    // An unsupported header length, with the last byte on the settling byte.
    send_file(32'd15, 32'd10, 32'd10, 32'd1, 32'd1, 18, MagicOk);

    run_phase(220, 6);
    write_max_dimension(20'd1);
    run_phase(170, 6);
    steady = 1'b1;
    write_max_dimension(20'hFFFFF);
    run_phase(260, 8);
    steady = 1'b0;
    write_max_dimension(20'd0);
    run_phase(130, 5);
    write_max_dimension(20'($urandom_range(1, 4000)));
    run_phase(210, 8);
    write_max_dimension(20'($urandom_range(1, 20'hFFFFF)));
    run_phase(210, 8);
    write_max_dimension(MaxDimReset);
    run_phase(210, 8);

    while (predictor.expected_headers.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (predictor.mismatches == 0 && predictor.expected_headers.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* bmp_header_metadata_parser_core.f */
hw/rtl/bmphdr_pkg.sv
hw/rtl/bmphdr_parse.sv
hw/rtl/bmphdr_check.sv
hw/rtl/bmp_header_metadata_parser_core.sv
test/tb_bmp_header_metadata_parser_core.sv
